// File: rtl/kot_pkg.sv
package kot_pkg;

  // Token kinds
  localparam logic [4:0] KIND_ID    = 5'd0;
  localparam logic [4:0] KIND_NUM   = 5'd1;
  localparam logic [4:0] KIND_INT   = 5'd2;
  localparam logic [4:0] KIND_FLOAT = 5'd3;
  localparam logic [4:0] KIND_PRINT = 5'd4;
  localparam logic [4:0] KIND_IF    = 5'd5;
  localparam logic [4:0] KIND_ELSE  = 5'd6;
  localparam logic [4:0] KIND_FOR   = 5'd7;
  localparam logic [4:0] KIND_PLUS  = 5'd8;
  localparam logic [4:0] KIND_MINUS = 5'd9;
  localparam logic [4:0] KIND_STAR  = 5'd10;
  localparam logic [4:0] KIND_SLASH = 5'd11;
  localparam logic [4:0] KIND_EQ    = 5'd12;
  localparam logic [4:0] KIND_SEMI  = 5'd13;
  localparam logic [4:0] KIND_LPAR  = 5'd14;
  localparam logic [4:0] KIND_RPAR  = 5'd15;
  localparam logic [4:0] KIND_LBRC  = 5'd16;
  localparam logic [4:0] KIND_RBRC  = 5'd17;
  localparam logic [4:0] KIND_GT    = 5'd18;
  localparam logic [4:0] KIND_LT    = 5'd19;
  localparam logic [4:0] KIND_END   = 5'd20;

  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Keyword table: longest keyword is five bytes
  localparam int KW_SPAN = 5;
  localparam int KW_COUNT = 6;

  typedef logic [7:0] kw_buf_t [KW_SPAN];

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SPAN] = '{
    '{"i", "n", "t", 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t"},
    '{"p", "r", "i", "n", "t"},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd5, 3'd2, 3'd4, 3'd3};
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    KIND_INT, KIND_FLOAT, KIND_PRINT, KIND_IF, KIND_ELSE, KIND_FOR
  };

  // Result queue depth; three free entries are needed to take a byte
  localparam int QUEUE_DEPTH = 6;
  localparam int SLOTS = 3;

  typedef struct packed {
    logic [SLOTS-1:0] valid;
    logic [SLOTS-1:0] final_res;
  } slot_ctl_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Returns {hit, kind} for the one-byte operator tokens
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] res;
    case (c)
      "+": res = {1'b1, KIND_PLUS};
      "-": res = {1'b1, KIND_MINUS};
      "*": res = {1'b1, KIND_STAR};
      "/": res = {1'b1, KIND_SLASH};
      "=": res = {1'b1, KIND_EQ};
      ";": res = {1'b1, KIND_SEMI};
      "(": res = {1'b1, KIND_LPAR};
      ")": res = {1'b1, KIND_RPAR};
      "{": res = {1'b1, KIND_LBRC};
      "}": res = {1'b1, KIND_RBRC};
      ">": res = {1'b1, KIND_GT};
      "<": res = {1'b1, KIND_LT};
      default: res = {1'b0, KIND_ID};
    endcase
    return res;
  endfunction

  // len is the token length when it is at most five, else zero
  function automatic logic [4:0] kw_kind(input kw_buf_t chars, input logic [2:0] len);
    logic [4:0] res;
    logic same;
    res = KIND_ID;
    for (int k = 0; k < KW_COUNT; k++) begin
      same = (len == KW_LEN[k]);
      for (int j = 0; j < KW_SPAN; j++) begin
        if (3'(j) < KW_LEN[k] && chars[j] != KW_TEXT[k][j]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        res = KW_KIND[k];
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/kot_scan.sv
module kot_scan #(
  parameter int POS_WIDTH = 32,
  parameter int LEN_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 has_char,
  input  logic [7:0]           ch,
  input  logic                 last,
  output kot_pkg::slot_ctl_t   slot_ctl,
  output logic [4:0]           slot_kind  [kot_pkg::SLOTS],
  output logic [POS_WIDTH-1:0] slot_start [kot_pkg::SLOTS],
  output logic [LEN_WIDTH-1:0] slot_len   [kot_pkg::SLOTS]
);

  localparam int KIW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ID   = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;

  logic [1:0]           mode, mode_next;
  logic                 dot_seen, dot_seen_next;
  logic [POS_WIDTH-1:0] position, position_next;
  logic [POS_WIDTH-1:0] token_start, token_start_next;
  logic [LEN_WIDTH-1:0] token_length, token_length_next;
  logic [7:0]           keyword_chars [KEYWORD_CHARS];

  logic                 alpha, digit, alnum, dot_ch;
  logic [5:0]           op;
  logic                 taken, closed, bgn, appnd, op_emit, flush_last;
  logic [LEN_WIDTH-1:0] alen;
  logic                 kc_we;
  logic [KIW-1:0]       kc_idx;
  kot_pkg::kw_buf_t     cur_chars, mid_chars;
  logic [1:0]           mid_mode;
  logic [POS_WIDTH-1:0] mid_start, pos_inc;
  logic [LEN_WIDTH-1:0] mid_len;

  function automatic logic [2:0] len_code(input logic [LEN_WIDTH-1:0] t);
    return (t <= LEN_WIDTH'(5)) ? t[2:0] : 3'd0;
  endfunction

  always_comb begin
    alpha   = kot_pkg::is_alpha(ch);
    digit   = kot_pkg::is_digit(ch);
    alnum   = alpha || digit || (ch == kot_pkg::CH_UNDER);
    dot_ch  = (ch == kot_pkg::CH_DOT);
    op      = kot_pkg::op_kind(ch);
    taken   = 1'b0;
    closed  = 1'b0;
    bgn     = 1'b0;
    appnd   = 1'b0;
    op_emit = 1'b0;
    mid_mode = mode;
    dot_seen_next = dot_seen;
    mid_start = token_start;
    pos_inc = position;

    if (has_char) begin
      case (mode)
        MODE_ID: begin
          if (alnum) begin
            appnd = 1'b1;
            taken = 1'b1;
          end else begin
            closed = 1'b1;
          end
        end
        MODE_NUM: begin
          if (digit) begin
            appnd = 1'b1;
            taken = 1'b1;
          end else if (dot_ch && !dot_seen) begin
            appnd = 1'b1;
            dot_seen_next = 1'b1;
            taken = 1'b1;
          end else begin
            closed = 1'b1;
            // drop a second dot
            taken = dot_ch;
          end
        end
        default: ;
      endcase
      if (closed) begin
        mid_mode = MODE_IDLE;
        dot_seen_next = 1'b0;
      end
      if (!taken) begin
        if (alpha || digit) begin
          bgn = 1'b1;
          appnd = 1'b1;
          mid_mode = alpha ? MODE_ID : MODE_NUM;
          dot_seen_next = 1'b0;
          mid_start = position;
        end else if (op[5]) begin
          op_emit = 1'b1;
        end
      end
      pos_inc = position + POS_WIDTH'(1);
    end

    alen = bgn ? '0 : token_length;
    kc_we = appnd && (alen < LEN_WIDTH'(KEYWORD_CHARS));
    kc_idx = alen[KIW-1:0];
    if (appnd) begin
      mid_len = (alen == '1) ? alen : alen + LEN_WIDTH'(1);
    end else begin
      mid_len = token_length;
    end

    for (int j = 0; j < kot_pkg::KW_SPAN; j++) begin
      cur_chars[j] = keyword_chars[j];
      mid_chars[j] = (kc_we && kc_idx == KIW'(j)) ? ch : keyword_chars[j];
    end

    flush_last = last && (mid_mode != MODE_IDLE);

    // token closed by this byte
    slot_kind[0]  = (mode == MODE_ID) ?
                    kot_pkg::kw_kind(cur_chars, len_code(token_length)) : kot_pkg::KIND_NUM;
    slot_start[0] = token_start;
    slot_len[0]   = token_length;

    // operator token, or the token still open at the end of the source
    if (op_emit) begin
      slot_kind[1]  = op[4:0];
      slot_start[1] = position;
      slot_len[1]   = LEN_WIDTH'(1);
    end else begin
      slot_kind[1]  = (mid_mode == MODE_ID) ?
                      kot_pkg::kw_kind(mid_chars, len_code(mid_len)) : kot_pkg::KIND_NUM;
      slot_start[1] = mid_start;
      slot_len[1]   = mid_len;
    end

    slot_kind[2]  = kot_pkg::KIND_END;
    slot_start[2] = pos_inc;
    slot_len[2]   = '0;

    slot_ctl.valid = {last, op_emit || flush_last, closed};
    slot_ctl.final_res[2] = last;
    slot_ctl.final_res[1] = slot_ctl.valid[1] && !last;
    slot_ctl.final_res[0] = closed && !slot_ctl.valid[1] && !last;

    if (last) begin
      mode_next = MODE_IDLE;
      dot_seen_next = 1'b0;
      position_next = '0;
      token_start_next = '0;
      token_length_next = '0;
    end else begin
      mode_next = mid_mode;
      position_next = pos_inc;
      token_start_next = mid_start;
      token_length_next = mid_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      dot_seen <= 1'b0;
      position <= '0;
      token_start <= '0;
      token_length <= '0;
    end else if (fire) begin
      mode <= mode_next;
      dot_seen <= dot_seen_next;
      position <= position_next;
      token_start <= token_start_next;
      token_length <= token_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && kc_we) begin
      keyword_chars[kc_idx] <= ch;
    end
  end

endmodule

// File: rtl/kot_queue.sv
module kot_queue #(
  parameter int POS_WIDTH = 32,
  parameter int LEN_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  kot_pkg::slot_ctl_t   slot_ctl,
  input  logic [4:0]           slot_kind  [kot_pkg::SLOTS],
  input  logic [POS_WIDTH-1:0] slot_start [kot_pkg::SLOTS],
  input  logic [LEN_WIDTH-1:0] slot_len   [kot_pkg::SLOTS],
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           kind,
  output logic [POS_WIDTH-1:0] start_res,
  output logic [LEN_WIDTH-1:0] length,
  output logic                 final_res
);

  localparam int DEPTH = kot_pkg::QUEUE_DEPTH;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count, count_next, base;
  logic [4:0]           q_kind  [DEPTH];
  logic [POS_WIDTH-1:0] q_start [DEPTH];
  logic [LEN_WIDTH-1:0] q_len   [DEPTH];
  logic                 q_final [DEPTH];
  logic [4:0]           kind_next  [DEPTH];
  logic [POS_WIDTH-1:0] start_next [DEPTH];
  logic [LEN_WIDTH-1:0] len_next   [DEPTH];
  logic                 final_next [DEPTH];
  logic [CW-1:0]        slot_pos [kot_pkg::SLOTS];
  logic                 pop;
  logic [1:0]           n_push;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= CW'(DEPTH - kot_pkg::SLOTS));
  assign kind      = q_kind[0];
  assign start_res = q_start[0];
  assign length    = q_len[0];
  assign final_res = q_final[0];

  always_comb begin
    base = count - CW'(pop);
    // pack valid slots into consecutive entries
    slot_pos[0] = base;
    slot_pos[1] = base + CW'(slot_ctl.valid[0]);
    slot_pos[2] = base + CW'(slot_ctl.valid[0]) + CW'(slot_ctl.valid[1]);
    n_push = push ? (2'(slot_ctl.valid[0]) + 2'(slot_ctl.valid[1]) + 2'(slot_ctl.valid[2]))
                  : 2'd0;
    count_next = base + CW'(n_push);

    for (int i = 0; i < DEPTH - 1; i++) begin
      kind_next[i]  = pop ? q_kind[i+1]  : q_kind[i];
      start_next[i] = pop ? q_start[i+1] : q_start[i];
      len_next[i]   = pop ? q_len[i+1]   : q_len[i];
      final_next[i] = pop ? q_final[i+1] : q_final[i];
    end
    kind_next[DEPTH-1]  = q_kind[DEPTH-1];
    start_next[DEPTH-1] = q_start[DEPTH-1];
    len_next[DEPTH-1]   = q_len[DEPTH-1];
    final_next[DEPTH-1] = q_final[DEPTH-1];

    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < kot_pkg::SLOTS; j++) begin
        if (push && slot_ctl.valid[j] && slot_pos[j] == CW'(i)) begin
          kind_next[i]  = slot_kind[j];
          start_next[i] = slot_start[j];
          len_next[i]   = slot_len[j];
          final_next[i] = slot_ctl.final_res[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q_kind  <= kind_next;
    q_start <= start_next;
    q_len   <= len_next;
    q_final <= final_next;
  end

endmodule

// File: rtl/keyword_operator_tokenizer.sv
// Tokenizer for a small C-like language. Source bytes enter on the input
// channel (in_valid / in_stall), one byte per transfer, with has_char = 0 for
// an empty end marker and last = 1 on the final item of a source. Token
// records leave on the output channel (out_valid / out_stall): kind, start
// offset, length, and final_res on the last record caused by one input.
// A record is written into the result queue when the byte that closes it is
// taken. Throughput: one byte per cycle while the queue has room. The lexer
// state updates once per taken byte; a byte makes up to three records
// (closed token, operator or flushed token, END), and the six-entry result
// queue drains one record per cycle while out_stall is low, so in_stall
// rises while fewer than three entries are free.
// Reset clears the lexer state (idle, position zero) and empties the queue;
// no clearing pass is needed. When the receiver holds out_stall the queue
// holds its head record and fills, then input stalls; nothing is lost.
module keyword_operator_tokenizer #(
  parameter int POS_WIDTH = 32,
  parameter int LEN_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 has_char,
  input  logic [7:0]           ch,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           kind,
  output logic [POS_WIDTH-1:0] start_res,
  output logic [LEN_WIDTH-1:0] length,
  output logic                 final_res
);

  kot_pkg::slot_ctl_t   slot_ctl;
  logic [4:0]           slot_kind  [kot_pkg::SLOTS];
  logic [POS_WIDTH-1:0] slot_start [kot_pkg::SLOTS];
  logic [LEN_WIDTH-1:0] slot_len   [kot_pkg::SLOTS];
  logic                 room;
  logic                 fire;

  assign in_stall = !room;
  assign fire     = in_valid && room;

  kot_scan #(
    .POS_WIDTH(POS_WIDTH),
    .LEN_WIDTH(LEN_WIDTH),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .has_char(has_char),
    .ch(ch),
    .last(last),
    .slot_ctl(slot_ctl),
    .slot_kind(slot_kind),
    .slot_start(slot_start),
    .slot_len(slot_len)
  );

  kot_queue #(
    .POS_WIDTH(POS_WIDTH),
    .LEN_WIDTH(LEN_WIDTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(fire),
    .slot_ctl(slot_ctl),
    .slot_kind(slot_kind),
    .slot_start(slot_start),
    .slot_len(slot_len),
    .room(room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .start_res(start_res),
    .length(length),
    .final_res(final_res)
  );

endmodule

// File: sim/tb_keyword_operator_tokenizer.sv
`timescale 1ns / 1ps

module tb_keyword_operator_tokenizer;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_WORD = 12;

  typedef enum logic [1:0] {LEX_IDLE, LEX_WORD, LEX_NUMBER} lex_mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        fin;
  } token_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        has_char;
  logic [7:0]  ch;
  logic        last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  kind;
  logic [31:0] start_res;
  logic [15:0] length;
  logic        final_res;

  // Lexer state mirrored by the predictor
  lex_mode_t   lx_mode;
  logic        lx_dot;
  logic [31:0] lx_pos;
  logic [31:0] lx_start;
  logic [15:0] lx_len;
  logic [7:0]  lx_head [5];

  token_t      token_q [$];
  token_t      new_toks [$];
  logic [7:0]  piece [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int n_bytes = 0;
  int n_sources = 0;
  int n_checked = 0;
  int n_errors = 0;

  string word_list [] = '{"int", "float", "print", "if", "else", "for", "in", "floats",
                          "printf", "iff", "els", "fort", "Int", "i_f", "x1"};
  string op_text = "+-*/=;(){}><";

  keyword_operator_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .has_char  (has_char),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .start_res (start_res),
    .length    (length),
    .final_res (final_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
               token_q.size());
      $display("tb_keyword_operator_tokenizer failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted record against the oldest prediction
  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("unexpected record: kind %0d start %0d len %0d final %0b",
                   kind, start_res, length, final_res);
        end
      end else begin
        want = token_q.pop_front();
        n_checked++;
        if (kind !== want.kind || start_res !== want.start || length !== want.len ||
            final_res !== want.fin) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("record mismatch: expected kind %0d start %0d len %0d final %0b",
                     want.kind, want.start, want.len, want.fin);
            $display("                 got      kind %0d start %0d len %0d final %0b",
                     kind, start_res, length, final_res);
          end
        end
      end
    end
  end

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword lookup; anything longer than five bytes stays a plain identifier
  function automatic logic [4:0] word_kind();
    logic [39:0] w;
    w = '0;
    if (lx_len > 16'd5) return kot_pkg::KIND_ID;
    for (int j = 0; j < lx_len; j++) w = {w[31:0], lx_head[j]};
    case (w)
      "int":   return kot_pkg::KIND_INT;
      "float": return kot_pkg::KIND_FLOAT;
      "print": return kot_pkg::KIND_PRINT;
      "if":    return kot_pkg::KIND_IF;
      "else":  return kot_pkg::KIND_ELSE;
      "for":   return kot_pkg::KIND_FOR;
      default: return kot_pkg::KIND_ID;
    endcase
  endfunction

  task automatic emit_token(input logic [4:0] k, input logic [31:0] s, input logic [15:0] n);
    new_toks.insert(new_toks.size(), token_t'{k, s, n, 1'b0});
  endtask

  task automatic piece_add(input logic [7:0] b);
    piece.insert(piece.size(), b);
  endtask

  task automatic add_char(input logic [7:0] c);
    if (lx_len < 16'd5) lx_head[lx_len] = c;
    if (lx_len != 16'hFFFF) lx_len++;
  endtask

  task automatic begin_token(input lex_mode_t m, input logic [7:0] c);
    lx_mode = m;
    lx_dot = 1'b0;
    lx_start = lx_pos;
    lx_len = '0;
    add_char(c);
  endtask

  task automatic close_token();
    if (lx_mode == LEX_WORD) emit_token(word_kind(), lx_start, lx_len);
    else if (lx_mode == LEX_NUMBER) emit_token(kot_pkg::KIND_NUM, lx_start, lx_len);
    lx_mode = LEX_IDLE;
    lx_dot = 1'b0;
  endtask

  task automatic clear_lexer();
    lx_mode = LEX_IDLE;
    lx_dot = 1'b0;
    lx_pos = '0;
    lx_start = '0;
    lx_len = '0;
  endtask

  task automatic predict_tokens(input logic hc, input logic [7:0] c, input logic lst);
    logic taken;
    new_toks.delete();
    if (hc) begin
      taken = 1'b0;
      if (lx_mode == LEX_WORD) begin
        if (letter_byte(c) || digit_byte(c) || c == kot_pkg::CH_UNDER) begin
          add_char(c);
          taken = 1'b1;
        end else begin
          close_token();
        end
      end else if (lx_mode == LEX_NUMBER) begin
        if (digit_byte(c)) begin
          add_char(c);
          taken = 1'b1;
        end else if (c == kot_pkg::CH_DOT && !lx_dot) begin
          add_char(c);
          lx_dot = 1'b1;
          taken = 1'b1;
        end else begin
          close_token();
          // drop a second dot
          taken = (c == kot_pkg::CH_DOT);
        end
      end
      if (!taken) begin
        if (letter_byte(c)) begin_token(LEX_WORD, c);
        else if (digit_byte(c)) begin_token(LEX_NUMBER, c);
        else begin
          case (c)
            "+": emit_token(kot_pkg::KIND_PLUS, lx_pos, 16'd1);
            "-": emit_token(kot_pkg::KIND_MINUS, lx_pos, 16'd1);
            "*": emit_token(kot_pkg::KIND_STAR, lx_pos, 16'd1);
            "/": emit_token(kot_pkg::KIND_SLASH, lx_pos, 16'd1);
            "=": emit_token(kot_pkg::KIND_EQ, lx_pos, 16'd1);
            ";": emit_token(kot_pkg::KIND_SEMI, lx_pos, 16'd1);
            "(": emit_token(kot_pkg::KIND_LPAR, lx_pos, 16'd1);
            ")": emit_token(kot_pkg::KIND_RPAR, lx_pos, 16'd1);
            "{": emit_token(kot_pkg::KIND_LBRC, lx_pos, 16'd1);
            "}": emit_token(kot_pkg::KIND_RBRC, lx_pos, 16'd1);
            ">": emit_token(kot_pkg::KIND_GT, lx_pos, 16'd1);
            "<": emit_token(kot_pkg::KIND_LT, lx_pos, 16'd1);
            default: ;
          endcase
        end
      end
      lx_pos++;
    end
    if (lst) begin
      close_token();
      emit_token(kot_pkg::KIND_END, lx_pos, 16'd0);
      clear_lexer();
    end
    if (new_toks.size() != 0) begin
      new_toks[new_toks.size() - 1].fin = 1'b1;
    end
    foreach (new_toks[i]) token_q.insert(token_q.size(), new_toks[i]);
  endtask

  task automatic send_item(input logic hc, input logic [7:0] c, input logic lst);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    has_char <= hc;
    ch <= c;
    last <= lst;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_tokens(hc, c, lst);
    if (hc) n_bytes++;
    if (lst) n_sources++;
  endtask

  task automatic send_text(input string s, input logic end_source);
    for (int i = 0; i < s.len(); i++) send_item(1'b1, s[i], end_source && i == s.len() - 1);
  endtask

  // Hold the input off until every predicted record has drained
  task automatic wait_for_tokens();
    @(negedge clk);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? "a" + 8'(r) : "A" + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(9);
    if (r < 7) return rand_letter();
    if (r < 9) return rand_digit();
    return kot_pkg::CH_UNDER;
  endfunction

  task automatic test_keywords_and_operators();
    send_text("int+float-print*if/else=for;(){}><", 1'b1);
  endtask

  task automatic test_edge_bytes();
    // number cut by a second dot, dot after a word, stray underscore
    send_text("9.5.x._", 1'b0);
    send_item(1'b1, 8'h80, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b0, 8'($urandom_range(255)), 1'b0);
    // closed word, operator and end marker from one byte
    send_text("ab+", 1'b1);
    send_text("7", 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b0, 8'hFF, 1'b1);
    send_text(".", 1'b0);
    send_item(1'b0, 8'h55, 1'b1);
  endtask

  task automatic test_long_identifier();
    // keyword text at the head of a longer word must stay a plain identifier
    send_text("print", 1'b0);
    for (int i = 5; i < LONG_WORD; i++) send_item(1'b1, word_char(), 1'b0);
    send_item(1'b1, ";", 1'b1);
  endtask

  task automatic test_random_sources(input int idle, input int stall, input int n_items);
    int    sent;
    int    budget;
    int    src;
    int    pick;
    string w;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      budget = $urandom_range(30, 1);
      src = 0;
      while (src < budget) begin
        piece.delete();
        pick = $urandom_range(99);
        if (pick < 15) begin
          w = word_list[$urandom_range(word_list.size() - 1)];
          for (int i = 0; i < w.len(); i++) piece_add(w[i]);
        end else if (pick < 35) begin
          piece_add(rand_letter());
          repeat ($urandom_range(7)) piece_add(word_char());
        end else if (pick < 55) begin
          repeat ($urandom_range(6, 1)) piece_add(rand_digit());
          if ($urandom_range(9) < 4) begin
            piece_add(kot_pkg::CH_DOT);
            repeat ($urandom_range(4)) piece_add(rand_digit());
            if ($urandom_range(9) < 2) begin
              piece_add(kot_pkg::CH_DOT);
              repeat ($urandom_range(3)) piece_add(rand_digit());
            end
          end
        end else if (pick < 72) begin
          piece_add(op_text[$urandom_range(11)]);
        end else if (pick < 87) begin
          case ($urandom_range(2))
            0: piece_add(8'h20);
            1: piece_add(8'h09);
            default: piece_add(8'h0A);
          endcase
        end else if (pick < 95) begin
          piece_add(8'($urandom_range(255)));
        end
        if (piece.size() == 0) begin
          send_item(1'b0, 8'($urandom_range(255)), 1'b0);
        end else begin
          foreach (piece[i]) send_item(1'b1, piece[i], 1'b0);
        end
        src += (piece.size() == 0) ? 1 : piece.size();
      end
      case ($urandom_range(3))
        0, 1: send_item(1'b0, 8'($urandom_range(255)), 1'b1);
        2: send_item(1'b1, op_text[$urandom_range(11)], 1'b1);
        default: send_item(1'b1, 8'($urandom_range(255)), 1'b1);
      endcase
      sent += src + 1;
    end
    wait_for_tokens();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    has_char = 1'b0;
    ch = 8'h00;
    last = 1'b0;
    clear_lexer();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_keywords_and_operators();
    test_edge_bytes();
    wait_for_tokens();
    test_long_identifier();
    wait_for_tokens();
    test_random_sources(0, 0, 40);
    test_random_sources(84, 0, 40);
    test_random_sources(0, 84, 40);
    test_random_sources(23, 23, 40);

    idle_pct = 0;
    stall_pct = 0;
    wait_for_tokens();
    repeat (20) @(posedge clk);
    $display("%0d source bytes in %0d sources, %0d token records checked, %0d errors",
             n_bytes, n_sources, n_checked, n_errors);
    $display("keywords, operators, numbers, skipped bytes, overlong words; idle/stall mixes");
    if (n_errors == 0 && token_q.size() == 0) begin
      $display("tb_keyword_operator_tokenizer passed");
    end else begin
      $display("tb_keyword_operator_tokenizer failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kot_pkg.sv
rtl/kot_scan.sv
rtl/kot_queue.sv
rtl/keyword_operator_tokenizer.sv
sim/tb_keyword_operator_tokenizer.sv
